FILE: rtl/fcpa_pkg.sv
package fcpa_pkg;

  // command codes
  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_PUT     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_MISALIGNED = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [1:0] CFG_CHUNK_COUNT = 2'd1;
  localparam logic [1:0] CFG_CHUNK_SIZE  = 2'd2;

  // reset values of the configuration registers
  localparam logic [31:0] POOL_BASE_RST   = 32'd0;
  localparam logic [10:0] CHUNK_COUNT_RST = 11'd1024;
  localparam logic [15:0] CHUNK_SIZE_RST  = 16'd64;

  // divider: 32-bit dividend, 16-bit divisor, quotient bits per cycle
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_ITERS = 32 / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS);

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] chunk_address;
  } request_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [9:0]  chunk_index;
    logic [2:0]  status;
    logic [10:0] free_left;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [15:0] remainder;
  } div_rsp_t;

endpackage

FILE: rtl/fcpa_div.sv
module fcpa_div (
  input  logic                clk,
  input  logic                rst,
  input  fcpa_pkg::div_req_t  req,
  output fcpa_pkg::div_rsp_t  rsp
);
  import fcpa_pkg::*;

  logic                 running;
  logic [DIV_CNT_W-1:0] iter;
  logic [31:0]          quo;
  logic [15:0]          rem;
  logic [15:0]          dvs;
  logic [31:0]          quo_next;
  logic [15:0]          rem_next;

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [16:0] r;
    logic [31:0] q;
    r = {1'b0, rem};
    q = quo;
    for (int k = 0; k < DIV_BITS; k++) begin
      r = {r[15:0], q[31]};
      q = {q[30:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[0] = 1'b1;
      end
    end
    quo_next = q;
    rem_next = r[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      iter     <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        iter    <= '0;
        quo     <= req.dividend;
        rem     <= '0;
        dvs     <= req.divisor;
      end else if (running) begin
        quo  <= quo_next;
        rem  <= rem_next;
        iter <= iter + 1'b1;
        if (iter == DIV_CNT_W'(DIV_ITERS - 1)) begin
          running       <= 1'b0;
          rsp.done      <= 1'b1;
          rsp.quotient  <= quo_next;
          rsp.remainder <= rem_next;
        end
      end
    end
  end

endmodule

FILE: rtl/fixed_chunk_pool_allocator_core.sv
// get: result strobe after the accepting edge, through stack read, multiply and add
// put: result strobe registered once the 4-bit-per-cycle divider returns its quotient
// restart, get on empty, put below base, unknown command: strobe in the next cycle
// one item at a time; busy is high until the result is registered
// reset (rst, synchronous) restores the registers and a full stack at once:
// a low-water mark stands in for the stack image, so no clearing pass runs
module fixed_chunk_pool_allocator_core #(
  parameter int unsigned MAX_CHUNKS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fcpa_pkg::request_t  request,
  output logic                done,
  output fcpa_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import fcpa_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_CHUNKS);
  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);
  // reset count is the register reset value clamped to the stack depth
  localparam int unsigned RESET_COUNT = (MAX_CHUNKS < 1024) ? MAX_CHUNKS : 1024;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET_READ,
    S_GET_MUL,
    S_PUT_DIV
  } state_t;

  state_t state;

  // configuration registers
  logic [31:0] pool_base;
  logic [10:0] chunk_count;
  logic [15:0] chunk_bytes;

  // stack bookkeeping
  logic [CNT_W-1:0] free_count;
  // lowest count since the last restart or reset: positions below it still hold
  // their own index, positions at or above it were pushed since then
  logic [CNT_W-1:0] low_mark;

  // free stack memory with registered read data
  logic [IDX_W-1:0] stack_mem [MAX_CHUNKS];
  logic [IDX_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_pos;
  logic             push_en;
  logic [IDX_W-1:0] push_pos;
  logic [IDX_W-1:0] push_val;

  // get path
  logic [CNT_W-1:0]    top_pos;
  logic [IDX_W-1:0]    top_idx;
  logic                from_mem;
  logic [IDX_W-1:0]    got_idx;
  logic [IDX_W-1:0]    sel_idx;
  logic [IDX_W+15:0]   prod;

  // effective config values
  logic [31:0]      n_wide;
  logic [CNT_W-1:0] n_eff;
  logic [15:0]      cs_eff;

  logic accept;
  logic put_ok_addr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // clamp chunk_count to 1 .. MAX_CHUNKS, chunk size 0 acts as 1
  always_comb begin
    n_wide = 32'(chunk_count);
    if (n_wide == 32'd0) n_wide = 32'd1;
    if (n_wide > 32'(MAX_CHUNKS)) n_wide = 32'(MAX_CHUNKS);
    n_eff  = n_wide[CNT_W-1:0];
    cs_eff = (chunk_bytes == 16'd0) ? 16'd1 : chunk_bytes;
  end

  assign top_pos     = free_count - CNT_W'(1);
  assign top_idx     = top_pos[IDX_W-1:0];
  assign rd_pos      = top_idx;
  assign put_ok_addr = (request.chunk_address >= pool_base);

  // a popped entry that was never pushed since restart holds its own position
  assign sel_idx = from_mem ? rd_data : got_idx;

  // divider runs only for a put whose address is at or above the base
  always_comb begin
    div_req.start    = accept && (request.command == CMD_PUT) && put_ok_addr;
    div_req.dividend = request.chunk_address - pool_base;
    div_req.divisor  = cs_eff;
  end

  fcpa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // push decision once the quotient is back
  always_comb begin
    push_en  = (state == S_PUT_DIV) && div_rsp.done && (div_rsp.remainder == 16'd0) &&
               (div_rsp.quotient < 32'(n_eff)) && (free_count < n_eff);
    push_pos = free_count[IDX_W-1:0];
    push_val = div_rsp.quotient[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (push_en) stack_mem[push_pos] <= push_val;
    rd_data <= stack_mem[rd_pos];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= POOL_BASE_RST;
      chunk_count <= CHUNK_COUNT_RST;
      chunk_bytes <= CHUNK_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POOL_BASE:   pool_base   <= cfg_data;
        CFG_CHUNK_COUNT: chunk_count <= cfg_data[10:0];
        CFG_CHUNK_SIZE:  chunk_bytes <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer with stack count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      free_count <= CNT_W'(RESET_COUNT);
      low_mark   <= CNT_W'(RESET_COUNT);
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result.granted_address <= '0;
            result.chunk_index     <= '0;
            result.status          <= ST_OK;
            result.free_left       <= 11'(free_count);
            unique case (request.command)
              CMD_GET: begin
                if (free_count == '0) begin
                  result.status <= ST_EMPTY;
                  done          <= 1'b1;
                end else begin
                  // pop now; data comes back from the memory next cycle
                  from_mem   <= (top_pos >= low_mark);
                  got_idx    <= top_idx;
                  free_count <= top_pos;
                  if (top_pos < low_mark) low_mark <= top_pos;
                  state <= S_GET_READ;
                end
              end
              CMD_PUT: begin
                if (!put_ok_addr) begin
                  result.status <= ST_RANGE;
                  done          <= 1'b1;
                end else begin
                  state <= S_PUT_DIV;
                end
              end
              CMD_RESTART: begin
                // all positions read as their own index again
                free_count       <= n_eff;
                low_mark         <= n_eff;
                result.free_left <= 11'(n_eff);
                done             <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_GET_READ: begin
          got_idx <= sel_idx;
          prod    <= sel_idx * cs_eff;
          state   <= S_GET_MUL;
        end
        S_GET_MUL: begin
          result.granted_address <= pool_base + 32'(prod);
          result.chunk_index     <= 10'(got_idx);
          result.status          <= ST_OK;
          result.free_left       <= 11'(free_count);
          done                   <= 1'b1;
          state                  <= S_IDLE;
        end
        S_PUT_DIV: begin
          if (div_rsp.done) begin
            // checks in priority order: alignment, range, full stack
            if (div_rsp.remainder != 16'd0) begin
              result.status <= ST_MISALIGNED;
            end else if (div_rsp.quotient >= 32'(n_eff)) begin
              result.status <= ST_RANGE;
            end else if (free_count >= n_eff) begin
              result.status <= ST_FULL;
            end else begin
              result.status      <= ST_OK;
              result.chunk_index <= 10'(div_rsp.quotient);
              result.free_left   <= 11'(free_count + CNT_W'(1));
              free_count         <= free_count + CNT_W'(1);
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/fcpa_checker.sv
module fcpa_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input fcpa_pkg::result_t result
);
  import fcpa_pkg::*;

  // a result only comes out once the block is free again
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // every accepted beat either starts work or answers next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat dropped");

  // failed items grant nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |->
      ((result.granted_address == 32'd0) && (result.chunk_index == 10'd0)))
    else $error("failed item carries an address or index");

  // empty answer means nothing is left
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_EMPTY)) |-> (result.free_left == 11'd0))
    else $error("empty status with chunks left");

endmodule

bind fixed_chunk_pool_allocator_core fcpa_checker u_fcpa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import fcpa_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_NONE   = 2'd3;  // no-op command
  localparam logic [1:0] CFG_UNUSED = 2'd3;  // register index with no register

  localparam int unsigned POOL_DEPTH     = 1024;
  localparam int unsigned SETTLE_CYCLES  = 16;    // longer than the put latency
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned NUM_ROWS       = 28;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned ITEMS_PER_PHASE = 115;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // one row of the directed table: a command beat or a register write
  typedef struct {
    row_kind_t   kind;
    logic [1:0]  code;   // command, or register index
    logic [31:0] value;  // chunk address, or register data
    bit          typed;  // answer below is taken as is
    result_t     want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  logic     done;
  result_t  result;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fixed_chunk_pool_allocator_core #(
    .MAX_CHUNKS(POOL_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the pool: registers, free index stack and its depth
  logic [31:0] pool_base_sh;
  logic [10:0] chunk_count_sh;
  logic [15:0] chunk_bytes_sh;
  logic [9:0]  free_ids [POOL_DEPTH];
  int unsigned free_depth;

  result_t     pool_answers [$];  // answers still owed by the block
  logic [31:0] held_chunks [$];   // addresses granted and not yet put back
  result_t     answer_due;
  int          mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;    // beats left in a stretch with no gaps
  stim_row_t   directed_rows [NUM_ROWS];

  function automatic result_t ans(logic [31:0] granted, logic [9:0] idx,
                                  logic [2:0] st, logic [10:0] left);
    result_t r;
    r.granted_address = granted;
    r.chunk_index = idx;
    r.status = st;
    r.free_left = left;
    return r;
  endfunction

  // chunk_count clamped to 1 .. pool depth
  function automatic int unsigned live_chunks();
    if (chunk_count_sh == 0) return 1;
    if (chunk_count_sh > POOL_DEPTH) return POOL_DEPTH;
    return 32'(chunk_count_sh);
  endfunction

  // a zero chunk size counts as one byte
  function automatic int unsigned live_size();
    return (chunk_bytes_sh == 0) ? 1 : 32'(chunk_bytes_sh);
  endfunction

  task automatic refill_pool(input int unsigned n);
    for (int i = 0; i < POOL_DEPTH; i++) free_ids[i] = i[9:0];
    free_depth = n;
  endtask

  // advance the shadow pool by one command and work out its answer
  task automatic apply_pool_command(input request_t req, output result_t r);
    int unsigned n;
    int unsigned cs;
    logic [31:0] off;
    logic [31:0] q;
    logic [9:0]  idx;
    n = live_chunks();
    cs = live_size();
    r = '0;
    case (req.command)
      CMD_GET: begin
        if (free_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          free_depth = free_depth - 1;
          idx = free_ids[free_depth];
          r.chunk_index = idx;
          // wraps modulo 2^32
          r.granted_address = pool_base_sh + 32'(idx) * 32'(cs);
        end
      end
      CMD_PUT: begin
        off = req.chunk_address - pool_base_sh;
        q = off / cs;
        // checks in order: below base, misaligned, beyond pool, stack full
        if (req.chunk_address < pool_base_sh) begin
          r.status = ST_RANGE;
        end else if (off % cs != 0) begin
          r.status = ST_MISALIGNED;
        end else if (q >= n) begin
          r.status = ST_RANGE;
        end else if (free_depth >= n) begin
          r.status = ST_FULL;
        end else begin
          free_ids[free_depth] = q[9:0];
          free_depth = free_depth + 1;
          r.chunk_index = q[9:0];
        end
      end
      CMD_RESTART: refill_pool(n);
      default: ;
    endcase
    r.free_left = free_depth[10:0];
  endtask

  // one command beat: random gap, wait for the block to take it, predict
  task automatic issue_request(input logic [1:0] cmd, input logic [31:0] addr,
                               input bit typed, input result_t want,
                               output result_t predicted);
    int unsigned gap;
    request_t req;
    req.command = cmd;
    req.chunk_address = addr;
    if (burst_left != 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    apply_pool_command(req, predicted);
    pool_answers.push_back(typed ? want : predicted);
  endtask

  // hold off until every answer is in, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pool_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no toggle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POOL_BASE:   pool_base_sh = data;
      CFG_CHUNK_COUNT: chunk_count_sh = data[10:0];
      CFG_CHUNK_SIZE:  chunk_bytes_sh = data[15:0];
      default: ;
    endcase
  endtask

  // pick a command and address for the random part, mostly well formed
  task automatic random_request(output logic [1:0] cmd, output logic [31:0] addr);
    int unsigned pick;
    int unsigned cs;
    int unsigned slot;
    cs = live_size();
    pick = $urandom_range(0, 99);
    addr = $urandom;
    if (pick < 45) begin
      cmd = CMD_GET;
    end else if (pick < 88) begin
      cmd = CMD_PUT;
      pick = $urandom_range(0, 9);
      if (pick < 5 && held_chunks.size() != 0) begin
        slot = $urandom_range(0, held_chunks.size() - 1);
        addr = held_chunks[slot];
        held_chunks.delete(slot);
      end else if (pick < 7) begin
        // aligned, index up to one past the pool
        addr = pool_base_sh + 32'($urandom_range(0, live_chunks())) * 32'(cs);
      end else if (pick == 7 && cs > 1) begin
        addr = pool_base_sh + 32'($urandom_range(0, live_chunks() - 1)) * 32'(cs)
               + 32'($urandom_range(1, cs - 1));
      end else if (pick == 9 && pool_base_sh != 0) begin
        addr = pool_base_sh - 32'($urandom_range(1, 4096));
      end
    end else if (pick < 94) begin
      cmd = CMD_RESTART;
    end else begin
      cmd = CMD_NONE;
    end
  endtask

  // result side: the block cannot be held off, so every strobe is a beat
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pool_answers.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: expected nothing, got %p", $time, result);
      end else begin
        answer_due = pool_answers.pop_front();
        if (result.granted_address !== answer_due.granted_address) begin
          mismatches++;
          $display("%0t: granted_address expected %h got %h", $time,
                   answer_due.granted_address, result.granted_address);
        end
        if (result.chunk_index !== answer_due.chunk_index) begin
          mismatches++;
          $display("%0t: chunk_index expected %0d got %0d", $time,
                   answer_due.chunk_index, result.chunk_index);
        end
        if (result.status !== answer_due.status) begin
          mismatches++;
          $display("%0t: status expected %0d got %0d", $time,
                   answer_due.status, result.status);
        end
        if (result.free_left !== answer_due.free_left) begin
          mismatches++;
          $display("%0t: free_left expected %0d got %0d", $time,
                   answer_due.free_left, result.free_left);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL fixed_chunk_pool_allocator_core");
      $finish;
    end
  end

  initial begin
    result_t     got;
    logic [1:0]  cmd;
    logic [31:0] addr;

    pool_base_sh = POOL_BASE_RST;
    chunk_count_sh = CHUNK_COUNT_RST;
    chunk_bytes_sh = CHUNK_SIZE_RST;
    refill_pool(live_chunks());

    // directed: reset pool is 1024 chunks of 64 bytes at address 0
    directed_rows = '{
      '{ROW_ITEM, CMD_GET,     32'h0000_0000, 1'b1, ans(32'h0000_FFC0, 10'd1023, ST_OK, 11'd1023)},
      '{ROW_ITEM, CMD_PUT,     32'h0000_FFC0, 1'b1, ans(32'h0, 10'd1023, ST_OK, 11'd1024)},
      // stack already full
      '{ROW_ITEM, CMD_PUT,     32'h0000_0000, 1'b1, ans(32'h0, 10'd0, ST_FULL, 11'd1024)},
      '{ROW_ITEM, CMD_PUT,     32'h0000_0001, 1'b1, ans(32'h0, 10'd0, ST_MISALIGNED, 11'd1024)},
      // aligned but far past the last chunk
      '{ROW_ITEM, CMD_PUT,     32'hFFFF_FFC0, 1'b1, ans(32'h0, 10'd0, ST_RANGE, 11'd1024)},
      '{ROW_ITEM, CMD_PUT,     32'hFFFF_FFFF, 1'b1, ans(32'h0, 10'd0, ST_MISALIGNED, 11'd1024)},
      '{ROW_ITEM, CMD_NONE,    32'hFFFF_FFFF, 1'b1, ans(32'h0, 10'd0, ST_OK, 11'd1024)},
      '{ROW_ITEM, CMD_GET,     32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_ITEM, CMD_GET,     32'h0000_0000, 1'b0, '0},
      '{ROW_ITEM, CMD_PUT,     32'h0000_FF80, 1'b0, '0},
      '{ROW_ITEM, CMD_RESTART, 32'h0000_0000, 1'b1, ans(32'h0, 10'd0, ST_OK, 11'd1024)},
      // two-chunk pool, zero size taken as one byte
      '{ROW_CFG,  CFG_POOL_BASE,   32'h1000_0000, 1'b0, '0},
      '{ROW_CFG,  CFG_CHUNK_COUNT, 32'd2,         1'b0, '0},
      '{ROW_CFG,  CFG_CHUNK_SIZE,  32'd0,         1'b0, '0},
      '{ROW_ITEM, CMD_RESTART, 32'h0000_0000, 1'b1, ans(32'h0, 10'd0, ST_OK, 11'd2)},
      '{ROW_ITEM, CMD_GET,     32'h0000_0000, 1'b1, ans(32'h1000_0001, 10'd1, ST_OK, 11'd1)},
      '{ROW_ITEM, CMD_GET,     32'h0000_0000, 1'b1, ans(32'h1000_0000, 10'd0, ST_OK, 11'd0)},
      '{ROW_ITEM, CMD_GET,     32'h0000_0000, 1'b1, ans(32'h0, 10'd0, ST_EMPTY, 11'd0)},
      // below the base
      '{ROW_ITEM, CMD_PUT,     32'h0FFF_FFFF, 1'b1, ans(32'h0, 10'd0, ST_RANGE, 11'd0)},
      '{ROW_ITEM, CMD_PUT,     32'h1000_0002, 1'b1, ans(32'h0, 10'd0, ST_RANGE, 11'd0)},
      '{ROW_ITEM, CMD_PUT,     32'h1000_0001, 1'b1, ans(32'h0, 10'd1, ST_OK, 11'd1)},
      // same chunk twice goes through
      '{ROW_ITEM, CMD_PUT,     32'h1000_0001, 1'b1, ans(32'h0, 10'd1, ST_OK, 11'd2)},
      '{ROW_ITEM, CMD_PUT,     32'h1000_0000, 1'b1, ans(32'h0, 10'd0, ST_FULL, 11'd2)},
      // top base, count clamped to the depth, largest size, dead index
      '{ROW_CFG,  CFG_POOL_BASE,   32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_CFG,  CFG_CHUNK_COUNT, 32'd2047,      1'b0, '0},
      '{ROW_CFG,  CFG_CHUNK_SIZE,  32'd65535,     1'b0, '0},
      '{ROW_CFG,  CFG_UNUSED,      32'hA5A5_5A5A, 1'b0, '0},
      '{ROW_ITEM, CMD_RESTART, 32'h0000_0000, 1'b1, ans(32'h0, 10'd0, ST_OK, 11'd1024)}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (i == 0 || directed_rows[i - 1].kind != ROW_CFG) wait_idle();
        write_reg(directed_rows[i].code, directed_rows[i].value);
        if (i == NUM_ROWS - 1 || directed_rows[i + 1].kind != ROW_CFG) cfg_valid <= 1'b0;
      end else begin
        issue_request(directed_rows[i].code, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want, got);
      end
    end
    // wrapped grant and a put of the chunk at the base, both predicted
    issue_request(CMD_GET, 32'h0, 1'b0, '0, got);
    issue_request(CMD_PUT, 32'hFFFF_FFFF, 1'b0, '0, got);

    // random phases, each under its own pool layout
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(CFG_POOL_BASE, POOL_BASE_RST);
          write_reg(CFG_CHUNK_COUNT, 32'(CHUNK_COUNT_RST));
          write_reg(CFG_CHUNK_SIZE, 32'(CHUNK_SIZE_RST));
        end
        1: begin
          write_reg(CFG_POOL_BASE, 32'h0);
          write_reg(CFG_CHUNK_COUNT, 32'd1);
          write_reg(CFG_CHUNK_SIZE, 32'd1);
        end
        2: begin
          write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
          write_reg(CFG_CHUNK_COUNT, 32'd2047);
          write_reg(CFG_CHUNK_SIZE, 32'd65535);
        end
        3: begin
          write_reg(CFG_CHUNK_SIZE, 32'd0);
          write_reg(CFG_CHUNK_COUNT, 32'd0);
          write_reg(CFG_POOL_BASE, 32'hFFFF_0000);
        end
        default: begin
          case ($urandom_range(0, 2))
            0: write_reg(CFG_POOL_BASE, 32'h0);
            1: write_reg(CFG_POOL_BASE, $urandom);
            default: write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF - $urandom_range(0, 1 << 20));
          endcase
          if ($urandom_range(0, 3) == 0) write_reg(CFG_CHUNK_COUNT, $urandom_range(0, 2047));
          else write_reg(CFG_CHUNK_COUNT, $urandom_range(1, 20));
          case ($urandom_range(0, 2))
            0: write_reg(CFG_CHUNK_SIZE, $urandom_range(0, 65535));
            1: write_reg(CFG_CHUNK_SIZE, 32'd1 << $urandom_range(0, 15));
            default: write_reg(CFG_CHUNK_SIZE, $urandom_range(1, 100));
          endcase
          if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
        end
      endcase
      cfg_valid <= 1'b0;

      // usually rebuild the stack; otherwise keep the old depth against the new count
      if ($urandom_range(0, 3) != 0) begin
        issue_request(CMD_RESTART, $urandom, 1'b0, '0, got);
        held_chunks.delete();
      end

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        random_request(cmd, addr);
        issue_request(cmd, addr, 1'b0, '0, got);
        if (cmd == CMD_GET && got.status == ST_OK) held_chunks.push_back(got.granted_address);
        if (cmd == CMD_RESTART) held_chunks.delete();
        // now and then drain everything before the next beat
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS fixed_chunk_pool_allocator_core");
    end else begin
      $display("FAIL fixed_chunk_pool_allocator_core");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fcpa_pkg.sv
rtl/fcpa_div.sv
rtl/fixed_chunk_pool_allocator_core.sv
rtl/fcpa_checker.sv
test/tb.sv
